// File: src/rtq_pkg.sv
// ----------------------------------------------------------------------------
// rtq_pkg
// Shared types and constants for the RSS Toeplitz queue select core.
// ----------------------------------------------------------------------------
package rtq_pkg;

    localparam int WORD_W      = 32;
    localparam int KEY_WORDS   = 4;
    localparam int MAX_QUEUES  = 256;
    localparam int QCNT_W      = 9;
    localparam int TSIZE_W     = 5;
    localparam int DIV_W       = $clog2(MAX_QUEUES + 1);
    localparam int QIDX_W      = 8;
    localparam int PORT_W      = 16;
    localparam int BITS_STAGE  = 8;
    localparam int CFG_IDX_W   = 3;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE_LOG2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_COUNT     = 3'd6;

    // reset values
    localparam logic [WORD_W-1:0]  RST_KEY_WORD_0      = 32'h8219_FA80;
    localparam logic [WORD_W-1:0]  RST_KEY_WORD_1      = 32'hA431_0659;
    localparam logic [WORD_W-1:0]  RST_KEY_WORD_2      = 32'h3E3F_9AAC;
    localparam logic [WORD_W-1:0]  RST_KEY_WORD_3      = 32'h3DAE_D6D9;
    localparam logic [WORD_W-1:0]  RST_LOCAL_IP        = 32'h0000_0000;
    localparam logic [TSIZE_W-1:0] RST_TABLE_SIZE_LOG2 = 5'd7;
    localparam logic [QCNT_W-1:0]  RST_QUEUE_COUNT     = 9'd1;

    typedef struct packed {
        logic [KEY_WORDS-1:0][WORD_W-1:0] key_word;
        logic [WORD_W-1:0]                local_ip;
        logic [WORD_W-1:0]                mask;
        logic [DIV_W-1:0]                 divisor;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] hash;
        logic [WORD_W-1:0] port_word;
    } hash_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] hash;
        logic [WORD_W-1:0] num;
        logic [DIV_W-1:0]  rem;
    } mod_beat_t;

endpackage

// File: src/rtq_cfg_regs.sv
// ----------------------------------------------------------------------------
// rtq_cfg_regs
// Configuration registers, with the derived hash mask and clamped divisor.
// ----------------------------------------------------------------------------
module rtq_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic [rtq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtq_pkg::WORD_W-1:0]   cfg_data,
    output rtq_pkg::cfg_t                cfg
);

    logic [rtq_pkg::KEY_WORDS-1:0][rtq_pkg::WORD_W-1:0] key_reg;
    logic [rtq_pkg::WORD_W-1:0]  local_ip_reg;
    logic [rtq_pkg::TSIZE_W-1:0] tsize_reg;
    logic [rtq_pkg::QCNT_W-1:0]  qcount_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg[0]   <= rtq_pkg::RST_KEY_WORD_0;
            key_reg[1]   <= rtq_pkg::RST_KEY_WORD_1;
            key_reg[2]   <= rtq_pkg::RST_KEY_WORD_2;
            key_reg[3]   <= rtq_pkg::RST_KEY_WORD_3;
            local_ip_reg <= rtq_pkg::RST_LOCAL_IP;
            tsize_reg    <= rtq_pkg::RST_TABLE_SIZE_LOG2;
            qcount_reg   <= rtq_pkg::RST_QUEUE_COUNT;
        end else if (cfg_valid) begin
            case (cfg_index)
                rtq_pkg::CFG_KEY_WORD_0:      key_reg[0]   <= cfg_data;
                rtq_pkg::CFG_KEY_WORD_1:      key_reg[1]   <= cfg_data;
                rtq_pkg::CFG_KEY_WORD_2:      key_reg[2]   <= cfg_data;
                rtq_pkg::CFG_KEY_WORD_3:      key_reg[3]   <= cfg_data;
                rtq_pkg::CFG_LOCAL_IP:        local_ip_reg <= cfg_data;
                rtq_pkg::CFG_TABLE_SIZE_LOG2: tsize_reg    <= cfg_data[rtq_pkg::TSIZE_W-1:0];
                rtq_pkg::CFG_QUEUE_COUNT:     qcount_reg   <= cfg_data[rtq_pkg::QCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.key_word = key_reg;
        cfg.local_ip = local_ip_reg;
        for (int i = 0; i < rtq_pkg::WORD_W; i++) begin
            cfg.mask[i] = (i < int'(tsize_reg));
        end
        // zero queues acts as one, oversized count is clamped
        if (qcount_reg == '0) begin
            cfg.divisor = rtq_pkg::DIV_W'(1);
        end else if (int'(qcount_reg) > rtq_pkg::MAX_QUEUES) begin
            cfg.divisor = rtq_pkg::DIV_W'(rtq_pkg::MAX_QUEUES);
        end else begin
            cfg.divisor = rtq_pkg::DIV_W'(qcount_reg);
        end
    end

endmodule

// File: src/rtq_hash_stage.sv
// ----------------------------------------------------------------------------
// rtq_hash_stage
// One pipeline stage: folds one 32-bit tuple word into the Toeplitz hash.
// ----------------------------------------------------------------------------
module rtq_hash_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rtq_pkg::hash_beat_t          in_data,
    input  logic [rtq_pkg::WORD_W-1:0]   word,
    input  logic [2*rtq_pkg::WORD_W-1:0] key_pair,
    output logic                         out_valid,
    input  logic                         out_ready,
    output rtq_pkg::hash_beat_t          out_data
);

    logic                valid_reg;
    logic                valid_next;
    rtq_pkg::hash_beat_t data_reg;
    rtq_pkg::hash_beat_t data_next;
    logic [rtq_pkg::WORD_W-1:0] acc;

    assign in_ready = !valid_reg || out_ready;

    // bit b of the word, counted from the MSB, selects key window at offset b
    always_comb begin
        acc = '0;
        for (int b = 0; b < rtq_pkg::WORD_W; b++) begin
            if (word[rtq_pkg::WORD_W-1-b]) begin
                acc = acc ^ key_pair[2*rtq_pkg::WORD_W-1-b -: rtq_pkg::WORD_W];
            end
        end
        data_next           = in_data;
        data_next.hash      = in_data.hash ^ acc;
        valid_next          = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("hash stage dropped or changed a stalled beat");
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> valid_reg)
        else $error("hash stage lost an accepted beat");
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !valid_reg)
        else $error("hash stage valid not cleared by reset");
`endif

endmodule

// File: src/rtq_mod_stage.sv
// ----------------------------------------------------------------------------
// rtq_mod_stage
// One pipeline stage of the restoring modulo: eight numerator bits per stage.
// ----------------------------------------------------------------------------
module rtq_mod_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  rtq_pkg::mod_beat_t         in_data,
    input  logic [rtq_pkg::DIV_W-1:0]  divisor,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rtq_pkg::mod_beat_t         out_data
);

    logic               valid_reg;
    logic               valid_next;
    rtq_pkg::mod_beat_t data_reg;
    rtq_pkg::mod_beat_t data_next;
    logic [rtq_pkg::DIV_W-1:0] r;
    logic [rtq_pkg::DIV_W:0]   t;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        r = in_data.rem;
        t = '0;
        for (int i = 0; i < rtq_pkg::BITS_STAGE; i++) begin
            t = {r, in_data.num[rtq_pkg::WORD_W-1-i]};
            if (t >= {1'b0, divisor}) begin
                t = t - {1'b0, divisor};
            end
            r = t[rtq_pkg::DIV_W-1:0];
        end
        data_next      = in_data;
        data_next.num  = in_data.num << rtq_pkg::BITS_STAGE;
        data_next.rem  = r;
        valid_next     = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("modulo stage dropped or changed a stalled beat");
    a_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> data_reg.num[rtq_pkg::BITS_STAGE-1:0] == '0)
        else $error("modulo stage numerator not shifted");
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> valid_reg)
        else $error("modulo stage lost an accepted beat");
`endif

endmodule

// File: src/rss_toeplitz_queue_select_core.sv
// Throughput: one flow tuple per cycle when not stalled; three hash
// stages (one tuple word each) and four modulo stages (eight numerator
// bits each) run in a chain. Each stage holds its beat under
// back-pressure and fills bubbles.
// Reset: aresetn synchronous active low; clears stage valids and restores
// configuration registers to their defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
// rss_toeplitz_queue_select_core
// Toeplitz hash over the IPv4 4-tuple and receive queue selection.
// ----------------------------------------------------------------------------
module rss_toeplitz_queue_select_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input tuple
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // remote_ip[31:0], remote_port[47:32], loc_port[63:48]
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // hash_value[31:0], queue_index[39:32]
);

    localparam int NMOD = rtq_pkg::WORD_W / rtq_pkg::BITS_STAGE;

    rtq_pkg::cfg_t       cfg;
    rtq_pkg::hash_beat_t h_in;
    rtq_pkg::hash_beat_t h_data [3];
    logic                h_valid [3];
    logic                h_ready [3];
    rtq_pkg::mod_beat_t  m_in   [NMOD];
    rtq_pkg::mod_beat_t  m_data [NMOD];
    logic                m_valid [NMOD];
    logic                m_ready [NMOD];
    logic [rtq_pkg::WORD_W-1:0] h_word [3];

    assign cfg_ready = 1'b1;

    rtq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign h_in.hash      = '0;
    assign h_in.port_word = {s_tdata[47:32], s_tdata[63:48]};

    assign h_word[0] = s_tdata[31:0];
    assign h_word[1] = cfg.local_ip;
    assign h_word[2] = h_data[1].port_word;

    for (genvar w = 0; w < 3; w++) begin : g_hash
        rtq_hash_stage u_hash (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  ((w == 0) ? s_tvalid : h_valid[(w == 0) ? 0 : w-1]),
            .in_ready  (h_ready[w]),
            .in_data   ((w == 0) ? h_in : h_data[(w == 0) ? 0 : w-1]),
            .word      (h_word[w]),
            .key_pair  ({cfg.key_word[w], cfg.key_word[w+1]}),
            .out_valid (h_valid[w]),
            .out_ready ((w == 2) ? m_ready[0] : h_ready[(w == 2) ? 2 : w+1]),
            .out_data  (h_data[w])
        );
    end

    assign s_tready = h_ready[0];

    // hash masked to the table size feeds the modulo chain
    always_comb begin
        m_in[0].hash = h_data[2].hash;
        m_in[0].num  = h_data[2].hash & cfg.mask;
        m_in[0].rem  = '0;
        for (int i = 1; i < NMOD; i++) begin
            m_in[i] = m_data[i-1];
        end
    end

    for (genvar k = 0; k < NMOD; k++) begin : g_mod
        rtq_mod_stage u_mod (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  ((k == 0) ? h_valid[2] : m_valid[(k == 0) ? 0 : k-1]),
            .in_ready  (m_ready[k]),
            .in_data   (m_in[k]),
            .divisor   (cfg.divisor),
            .out_valid (m_valid[k]),
            .out_ready ((k == NMOD-1) ? m_tready : m_ready[(k == NMOD-1) ? k : k+1]),
            .out_data  (m_data[k])
        );
    end

    assign m_tvalid = m_valid[NMOD-1];
    assign m_tdata  = {m_data[NMOD-1].rem[rtq_pkg::QIDX_W-1:0], m_data[NMOD-1].hash};

endmodule
